// ===== hdl/tc_pkg.sv =====
// triangle circumcenter package: field widths and request/response payload types
// no dependencies; imported by triangle_circumcenter
package tc_pkg;

   localparam int COORD_BITS  = 24;
   localparam int OUT_BITS    = 40;
   localparam int THRESH_BITS = 48;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] corner_a_x;
      logic signed [COORD_BITS-1:0] corner_a_y;
      logic signed [COORD_BITS-1:0] corner_b_x;
      logic signed [COORD_BITS-1:0] corner_b_y;
      logic signed [COORD_BITS-1:0] corner_c_x;
      logic signed [COORD_BITS-1:0] corner_c_y;
   } req_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] center_x;
      logic signed [OUT_BITS-1:0] center_y;
      logic                       degenerate;
      logic                       saturated;
   } rsp_type;

endpackage

// ===== hdl/triangle_circumcenter.sv =====
// triangle circumcenter: throughput one request per cycle while the output is not stalled
// by rsp_ready
// eight stages of products, sums and operand setup, then the restoring divider with one
// quotient bit per stage, 41 stages shared by both coordinates, then the output register
// synchronous reset empties the pipeline and sets min_determinant to 1
// depends on tc_pkg
module triangle_circumcenter
   import tc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [THRESH_BITS-1:0] csr_wdata
);

   localparam int CB   = COORD_BITS;
   localparam int DIFW = CB + 1;
   localparam int SQW  = 2 * CB;
   localparam int DETW = 2 * CB + 1;
   localparam int NRMW = 2 * CB + 1;
   localparam int DW   = 2 * CB + 4;
   localparam int PLW  = 2 * CB + 2;
   localparam int PHW  = 2 * CB + 3;
   localparam int TW   = 3 * CB + 3;
   localparam int NW   = 3 * CB + 5;
   localparam int NUMW = 3 * CB + 6;
   localparam int DENW = DW + 1;
   localparam int QB   = OUT_BITS + 1;
   localparam int NEXT = (NUMW > QB) ? NUMW : QB + 1;
   localparam int HIW  = NEXT - QB;
   localparam int CMPW = (HIW > DENW) ? HIW : DENW;
   localparam int MW   = (DW > THRESH_BITS) ? DW : THRESH_BITS;
   localparam int NST  = QB + 9;

   typedef struct packed {
      logic [DENW-1:0] rem_x;
      logic [DENW-1:0] rem_y;
      logic [QB-1:0]   low_x;
      logic [QB-1:0]   low_y;
      logic [QB-1:0]   q_x;
      logic [QB-1:0]   q_y;
      logic            ovf_x;
      logic            ovf_y;
      logic            neg_x;
      logic            neg_y;
      logic            degen;
      logic [DENW-1:0] den;
   } div_type;

   function automatic logic [DENW:0] div_step(logic [DENW-1:0] rem, logic nbit,
                                              logic [DENW-1:0] den);
      logic [DENW:0] t;
      logic [DENW:0] d;
      logic [DENW:0] r;
      t = {rem, nbit};
      d = {1'b0, den};
      r = t - d;
      if (t >= d) begin
         return {1'b1, r[DENW-1:0]};
      end
      return {1'b0, t[DENW-1:0]};
   endfunction

   // one quotient bit for both coordinates
   function automatic div_type div_next(div_type s);
      div_type       n;
      logic [DENW:0] sx;
      logic [DENW:0] sy;
      sx = div_step(s.rem_x, s.low_x[QB-1], s.den);
      sy = div_step(s.rem_y, s.low_y[QB-1], s.den);
      n = s;
      n.rem_x = sx[DENW-1:0];
      n.rem_y = sy[DENW-1:0];
      n.low_x = {s.low_x[QB-2:0], 1'b0};
      n.low_y = {s.low_y[QB-2:0], 1'b0};
      n.q_x   = {s.q_x[QB-2:0], sx[DENW]};
      n.q_y   = {s.q_y[QB-2:0], sy[DENW]};
      return n;
   endfunction

   // returns {saturated, value}
   function automatic logic [OUT_BITS:0] sat_quot(logic [QB-1:0] q, logic ovf, logic neg);
      logic [QB-1:0]       lim;
      logic [OUT_BITS-1:0] mn;
      logic [OUT_BITS-1:0] mx;
      lim = QB'(1) << (OUT_BITS - 1);
      mn  = OUT_BITS'(1) << (OUT_BITS - 1);
      mx  = ~mn;
      if (neg) begin
         if (ovf || q > lim) begin
            return {1'b1, mn};
         end
         return {1'b0, OUT_BITS'(0) - q[OUT_BITS-1:0]};
      end
      if (ovf || q > lim - QB'(1)) begin
         return {1'b1, mx};
      end
      return {1'b0, q[OUT_BITS-1:0]};
   endfunction

   logic [THRESH_BITS-1:0] min_det_ff;
   logic [NST-1:0]         v_ff;
   logic [NST-1:0]         en;

   // stage 0
   logic signed [CB-1:0]   ax0_ff, bx0_ff, cx0_ff;
   logic signed [DIFW-1:0] dx0_ff [3];
   logic signed [DIFW-1:0] dy0_ff [3];
   logic        [SQW-1:0]  sq0_ff [6];
   logic signed [SQW-1:0]  sq0_in [6];
   // stage 1
   logic signed [DETW-1:0] t1_ff [3];
   logic        [NRMW-1:0] nrm1_ff [3];
   logic signed [DIFW-1:0] dx1_ff [3];
   logic signed [DIFW-1:0] dy1_ff [3];
   // stage 2
   logic signed [DW-1:0]   d2_ff;
   logic signed [PLW-1:0]  plx2_ff [3];
   logic signed [PLW-1:0]  ply2_ff [3];
   logic signed [PHW-1:0]  phx2_ff [3];
   logic signed [PHW-1:0]  phy2_ff [3];
   // stage 3
   logic        [DW-1:0]   absd3_ff;
   logic                   dneg3_ff;
   logic signed [TW-1:0]   tx3_ff [3];
   logic signed [TW-1:0]   ty3_ff [3];
   // stage 4
   logic        [DW-1:0]   absd4_ff;
   logic                   dneg4_ff;
   logic                   degen4_ff;
   logic signed [NW-1:0]   nx4_ff, ny4_ff;
   // stage 5
   logic        [DW-1:0]   absd5_ff;
   logic        [DENW-1:0] den5_ff;
   logic                   degen5_ff, negx5_ff, negy5_ff;
   logic        [NW-1:0]   anx5_ff, any5_ff;
   // stage 6
   logic        [DENW-1:0] den6_ff;
   logic                   degen6_ff, negx6_ff, negy6_ff;
   logic        [NUMW-1:0] numx6_ff, numy6_ff;
   // stage 7 and divider stages
   div_type                div_ff [QB+1];
   logic        [NEXT-1:0] numx_ext, numy_ext;
   logic        [HIW-1:0]  hix, hiy;
   // output
   rsp_type                out_ff;
   rsp_type                out_in;

   // a stage moves when it is empty or the next stage moves
   assign en[NST-1] = !v_ff[NST-1] || rsp_ready;
   for (genvar i = 0; i < NST - 1; i++) begin : g_en
      assign en[i] = !v_ff[i] || en[i+1];
   end

   assign req_ready = en[0];
   assign rsp_valid = v_ff[NST-1];
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff       <= '0;
         min_det_ff <= THRESH_BITS'(1);
      end else begin
         if (csr_we) begin
            min_det_ff <= csr_wdata;
         end
         if (en[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int i = 1; i < NST; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   always_comb begin
      sq0_in[0] = req_data.corner_a_x * req_data.corner_a_x;
      sq0_in[1] = req_data.corner_a_y * req_data.corner_a_y;
      sq0_in[2] = req_data.corner_b_x * req_data.corner_b_x;
      sq0_in[3] = req_data.corner_b_y * req_data.corner_b_y;
      sq0_in[4] = req_data.corner_c_x * req_data.corner_c_x;
      sq0_in[5] = req_data.corner_c_y * req_data.corner_c_y;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         ax0_ff    <= req_data.corner_a_x;
         bx0_ff    <= req_data.corner_b_x;
         cx0_ff    <= req_data.corner_c_x;
         dx0_ff[0] <= DIFW'(req_data.corner_b_y) - DIFW'(req_data.corner_c_y);
         dx0_ff[1] <= DIFW'(req_data.corner_c_y) - DIFW'(req_data.corner_a_y);
         dx0_ff[2] <= DIFW'(req_data.corner_a_y) - DIFW'(req_data.corner_b_y);
         dy0_ff[0] <= DIFW'(req_data.corner_c_x) - DIFW'(req_data.corner_b_x);
         dy0_ff[1] <= DIFW'(req_data.corner_a_x) - DIFW'(req_data.corner_c_x);
         dy0_ff[2] <= DIFW'(req_data.corner_b_x) - DIFW'(req_data.corner_a_x);
         for (int k = 0; k < 6; k++) begin
            sq0_ff[k] <= sq0_in[k];
         end
      end
      if (en[1]) begin
         t1_ff[0] <= ax0_ff * dx0_ff[0];
         t1_ff[1] <= bx0_ff * dx0_ff[1];
         t1_ff[2] <= cx0_ff * dx0_ff[2];
         for (int k = 0; k < 3; k++) begin
            nrm1_ff[k] <= NRMW'(sq0_ff[2*k]) + NRMW'(sq0_ff[2*k+1]);
            dx1_ff[k]  <= dx0_ff[k];
            dy1_ff[k]  <= dy0_ff[k];
         end
      end
      if (en[2]) begin
         d2_ff <= (DW'(t1_ff[0]) + DW'(t1_ff[1]) + DW'(t1_ff[2])) <<< 1;
         // norm split in two halves to keep each multiplier narrow
         for (int k = 0; k < 3; k++) begin
            plx2_ff[k] <= $signed({1'b0, nrm1_ff[k][CB-1:0]}) * dx1_ff[k];
            ply2_ff[k] <= $signed({1'b0, nrm1_ff[k][CB-1:0]}) * dy1_ff[k];
            phx2_ff[k] <= $signed({1'b0, nrm1_ff[k][NRMW-1:CB]}) * dx1_ff[k];
            phy2_ff[k] <= $signed({1'b0, nrm1_ff[k][NRMW-1:CB]}) * dy1_ff[k];
         end
      end
      if (en[3]) begin
         dneg3_ff <= d2_ff[DW-1];
         absd3_ff <= d2_ff[DW-1] ? DW'(-d2_ff) : DW'(d2_ff);
         for (int k = 0; k < 3; k++) begin
            tx3_ff[k] <= (TW'(phx2_ff[k]) <<< CB) + TW'(plx2_ff[k]);
            ty3_ff[k] <= (TW'(phy2_ff[k]) <<< CB) + TW'(ply2_ff[k]);
         end
      end
      if (en[4]) begin
         absd4_ff  <= absd3_ff;
         dneg4_ff  <= dneg3_ff;
         degen4_ff <= (absd3_ff == '0) || (MW'(absd3_ff) < MW'(min_det_ff));
         nx4_ff    <= NW'(tx3_ff[0]) + NW'(tx3_ff[1]) + NW'(tx3_ff[2]);
         ny4_ff    <= NW'(ty3_ff[0]) + NW'(ty3_ff[1]) + NW'(ty3_ff[2]);
      end
      if (en[5]) begin
         absd5_ff  <= absd4_ff;
         den5_ff   <= {absd4_ff, 1'b0};
         degen5_ff <= degen4_ff;
         negx5_ff  <= nx4_ff[NW-1] ^ dneg4_ff;
         negy5_ff  <= ny4_ff[NW-1] ^ dneg4_ff;
         anx5_ff   <= nx4_ff[NW-1] ? NW'(-nx4_ff) : NW'(nx4_ff);
         any5_ff   <= ny4_ff[NW-1] ? NW'(-ny4_ff) : NW'(ny4_ff);
      end
      if (en[6]) begin
         den6_ff   <= den5_ff;
         degen6_ff <= degen5_ff;
         negx6_ff  <= negx5_ff;
         negy6_ff  <= negy5_ff;
         // rounding: (2|n| + |d|) / (2|d|)
         numx6_ff  <= NUMW'({anx5_ff, 1'b0}) + NUMW'(absd5_ff);
         numy6_ff  <= NUMW'({any5_ff, 1'b0}) + NUMW'(absd5_ff);
      end
   end

   assign numx_ext = NEXT'(numx6_ff);
   assign numy_ext = NEXT'(numy6_ff);
   assign hix      = numx_ext[NEXT-1:QB];
   assign hiy      = numy_ext[NEXT-1:QB];

   always_ff @(posedge clock) begin
      if (en[7]) begin
         // quotient of 2^QB or more cannot fit and is clipped anyway
         div_ff[0].ovf_x <= CMPW'(hix) >= CMPW'(den6_ff);
         div_ff[0].ovf_y <= CMPW'(hiy) >= CMPW'(den6_ff);
         div_ff[0].rem_x <= (CMPW'(hix) >= CMPW'(den6_ff)) ? '0 : DENW'(hix);
         div_ff[0].rem_y <= (CMPW'(hiy) >= CMPW'(den6_ff)) ? '0 : DENW'(hiy);
         div_ff[0].low_x <= numx_ext[QB-1:0];
         div_ff[0].low_y <= numy_ext[QB-1:0];
         div_ff[0].q_x   <= '0;
         div_ff[0].q_y   <= '0;
         div_ff[0].neg_x <= negx6_ff;
         div_ff[0].neg_y <= negy6_ff;
         div_ff[0].degen <= degen6_ff;
         div_ff[0].den   <= den6_ff;
      end
      for (int k = 1; k <= QB; k++) begin
         if (en[7+k]) begin
            div_ff[k] <= div_next(div_ff[k-1]);
         end
      end
   end

   always_comb begin
      logic [OUT_BITS:0] rx;
      logic [OUT_BITS:0] ry;
      rx = sat_quot(div_ff[QB].q_x, div_ff[QB].ovf_x, div_ff[QB].neg_x);
      ry = sat_quot(div_ff[QB].q_y, div_ff[QB].ovf_y, div_ff[QB].neg_y);
      if (div_ff[QB].degen) begin
         out_in = '{center_x: '0, center_y: '0, degenerate: 1'b1, saturated: 1'b0};
      end else begin
         out_in.center_x   = rx[OUT_BITS-1:0];
         out_in.center_y   = ry[OUT_BITS-1:0];
         out_in.degenerate = 1'b0;
         out_in.saturated  = rx[OUT_BITS] | ry[OUT_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en[NST-1]) begin
         out_ff <= out_in;
      end
   end

`ifndef SYNTHESIS
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |->
         rsp_data.center_x == '0 && rsp_data.center_y == '0 && !rsp_data.saturated)
      else $error("degenerate response with nonzero center");

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      v_ff[7+QB] && !div_ff[QB].degen |->
         div_ff[QB].rem_x < div_ff[QB].den && div_ff[QB].rem_y < div_ff[QB].den)
      else $error("divider remainder not below divisor");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !v_ff[0] |-> req_ready)
      else $error("empty first stage refuses a request");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");
`endif

endmodule

// ===== bench/testbench.sv =====
// testbench for triangle_circumcenter: random and directed triangles checked against
// an in-bench circumcenter predictor; depends on tc_pkg and triangle_circumcenter
`timescale 1ns / 100ps

module testbench;
   import tc_pkg::*;

   localparam int LATENCY = OUT_BITS + 10;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_type                rsp_data;
   logic                   csr_we;
   logic [THRESH_BITS-1:0] csr_wdata;

   logic [THRESH_BITS-1:0] min_det;
   req_type                pending_reqs[$];
   rsp_type                expected_centers[$];
   int                     error_count;
   bit                     quiet_in;
   bit                     quiet_out;
   bit                     hold_off;

   triangle_circumcenter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // rounded to nearest, ties away from zero, then clipped to 40 bits
   function automatic logic signed [OUT_BITS-1:0] div_round(
         input logic signed [127:0] num, input logic signed [127:0] den,
         inout bit clipped);
      logic [127:0]        an;
      logic [127:0]        ad;
      logic [127:0]        q;
      logic signed [127:0] sq;
      an = num[127] ? -num : num;
      ad = den[127] ? -den : den;
      q  = ((an << 1) + ad) / (ad << 1);
      sq = (num[127] != den[127]) ? -$signed(q) : $signed(q);
      if (sq > 128'sd549755813887) begin
         clipped = 1'b1;
         return 40'sh7f_ffff_ffff;
      end
      if (sq < -128'sd549755813888) begin
         clipped = 1'b1;
         return 40'sh80_0000_0000;
      end
      return sq[OUT_BITS-1:0];
   endfunction

   function automatic rsp_type predict_center(input req_type t);
      logic signed [127:0] ax, ay, bx, by, cx, cy, det, a2, b2, c2, nx, ny, mag;
      rsp_type r;
      bit      clipped;
      ax = t.corner_a_x; ay = t.corner_a_y;
      bx = t.corner_b_x; by = t.corner_b_y;
      cx = t.corner_c_x; cy = t.corner_c_y;
      det = 2 * (ax * (by - cy) + bx * (cy - ay) + cx * (ay - by));
      r = '0;
      mag = det[127] ? -det : det;
      if (det == 0 || mag < $signed({80'd0, min_det})) begin
         r.degenerate = 1'b1;
         return r;
      end
      a2 = ax * ax + ay * ay;
      b2 = bx * bx + by * by;
      c2 = cx * cx + cy * cy;
      nx = a2 * (by - cy) + b2 * (cy - ay) + c2 * (ay - by);
      ny = a2 * (cx - bx) + b2 * (ax - cx) + c2 * (bx - ax);
      clipped = 1'b0;
      r.center_x  = div_round(nx, det, clipped);
      r.center_y  = div_round(ny, det, clipped);
      r.saturated = clipped;
      return r;
   endfunction

   function automatic logic signed [COORD_BITS-1:0] rand_coord(input int span);
      unique case ($urandom_range(0, 9))
         0: return 24'sh7fffff;
         1: return 24'sh800000;
         2, 3: return COORD_BITS'($urandom);
         default: return COORD_BITS'($signed($urandom_range(0, 2 * span)) - span);
      endcase
   endfunction

   function automatic req_type make_tri(input int x0, input int y0, input int x1,
         input int y1, input int x2, input int y2);
      req_type t;
      t.corner_a_x = COORD_BITS'(x0); t.corner_a_y = COORD_BITS'(y0);
      t.corner_b_x = COORD_BITS'(x1); t.corner_b_y = COORD_BITS'(y1);
      t.corner_c_x = COORD_BITS'(x2); t.corner_c_y = COORD_BITS'(y2);
      return t;
   endfunction

   // driver: also predicts each request as it is accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_centers = {expected_centers, predict_center(req_data)};
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() > 0 && !hold_off
                  && (quiet_in || $urandom_range(0, 99) >= 13)) begin
               req_valid <= 1'b1;
               req_data  <= pending_reqs.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_centers.size() == 0) begin
               $display("%0t: response with none expected: %p", $time, rsp_data);
               error_count++;
            end else begin
               rsp_type want;
               want = expected_centers.pop_front();
               if (rsp_data.center_x !== want.center_x) begin
                  $display("%0t: center_x expected %0d actual %0d", $time,
                           want.center_x, rsp_data.center_x);
                  error_count++;
               end
               if (rsp_data.center_y !== want.center_y) begin
                  $display("%0t: center_y expected %0d actual %0d", $time,
                           want.center_y, rsp_data.center_y);
                  error_count++;
               end
               if (rsp_data.degenerate !== want.degenerate) begin
                  $display("%0t: degenerate expected %0b actual %0b", $time,
                           want.degenerate, rsp_data.degenerate);
                  error_count++;
               end
               if (rsp_data.saturated !== want.saturated) begin
                  $display("%0t: saturated expected %0b actual %0b", $time,
                           want.saturated, rsp_data.saturated);
                  error_count++;
               end
            end
         end
         rsp_ready <= quiet_out || $urandom_range(0, 99) >= 13;
      end
   end

   task automatic add_req(input req_type t);
      pending_reqs = {pending_reqs, t};
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_valid || expected_centers.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THRESH_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      min_det   <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic queue_random(input int count, input int span);
      for (int i = 0; i < count; i++)
         add_req(make_tri(rand_coord(span), rand_coord(span),
            rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span)));
   endtask

   initial begin
      reset       = 1'b1;
      csr_we      = 1'b0;
      csr_wdata   = '0;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_ready   = 1'b0;
      min_det     = THRESH_BITS'(1);
      error_count = 0;
      quiet_in    = 1'b0;
      quiet_out   = 1'b0;
      hold_off    = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: right triangle, collinear, coincident, extremes, tiny and huge centers
      add_req(make_tri(0, 0, 4096, 0, 0, 4096));
      add_req(make_tri(0, 0, 4096, 4096, 8192, 8192));
      add_req(make_tri(5, 5, 5, 5, 5, 5));
      add_req(make_tri(-8388608, -8388608, 8388607, -8388608, -8388608, 8388607));
      add_req(make_tri(8388607, 8388607, -8388608, 8388607, 8388607, -8388608));
      add_req(make_tri(0, 0, 1, 0, 0, 1));
      add_req(make_tri(-8388608, 0, 8388607, 1, 0, 0));
      add_req(make_tri(-8388608, -8388608, 8388607, 8388607, 0, 1));
      add_req(make_tri(100, -300, -4096, 7000, 12345, -9999));
      add_req(make_tri(-1, -1, 1, -1, 0, 1));
      wait_drained();

      // hold the sender off, then release it
      write_threshold(48'd0);
      queue_random(20, 50);
      hold_off = 1'b1;
      repeat (3) @(posedge clock);
      hold_off = 1'b0;
      wait_drained();

      write_threshold(48'hffff_ffff_ffff);
      queue_random(15, 8388607);
      wait_drained();

      write_threshold(48'd33554432);
      quiet_in  = 1'b1;
      quiet_out = 1'b1;
      queue_random(200, 4096);
      wait_drained();
      quiet_in  = 1'b0;
      quiet_out = 1'b0;

      write_threshold(48'd1);
      queue_random(250, 8388607);
      wait_drained();

      write_threshold(THRESH_BITS'($urandom_range(0, 32'h0fff_ffff)));
      queue_random(260, 2000);
      wait_drained();

      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
